@@ sv/sodp_pkg.sv @@
// ----------------------------------------------------------------------------
// sodp_pkg
// Shared types and constants of the sixth-order x-derivative stencil.
// ----------------------------------------------------------------------------
package sodp_pkg;

    // stencil half width and number of rows kept per column
    localparam int HALF_WIDTH = 3;
    localparam int ROWS_KEPT  = 2 * HALF_WIDTH;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_NUM_ROWS    = 2'd0,
        CFG_NUM_COLS    = 2'd1,
        CFG_INV_SPACING = 2'd2
    } cfg_index_t;

    typedef logic signed [31:0] sample_t;

    // column history, slice 0 is the most recent row
    typedef logic [ROWS_KEPT-1:0][31:0] hist_t;

    // one line store word: history of both weighted sums for one column
    typedef struct packed {
        hist_t first;
        hist_t second;
    } line_t;

    // per-request control carried down the pipeline
    typedef struct packed {
        logic emit;
        logic interior;
        logic last;
    } meta_t;

    // clamp window of the scaled sum so that the quotient by 60 fits 32 bits
    localparam logic signed [56:0] T_MIN = -57'sd128849018880;
    localparam logic signed [56:0] T_MAX = 57'sd128849018879;
    localparam logic [37:0]        X_MAX = 38'd257698037759;

    // floor(2^36 / 15), reciprocal for the divide by 15
    localparam logic [32:0] RECIP_15 = 33'd4581298449;

endpackage

@@ sv/sixth_order_x_derivative_of_products_core.sv @@
// ----------------------------------------------------------------------------
// sixth_order_x_derivative_of_products_core
// Grid points enter in row-major order, one request per cycle. Each point
// forms two weighted sums of u and v; a line store holds, for every column,
// the last six rows of both sums in one word that is read, shifted and
// written back per request (with forwarding for back-to-back requests on
// the same column). Three rows after a point arrives, its sixth-order
// central x-derivative scaled by the inverse spacing leaves the block,
// zero in the boundary margin. The pipeline takes one request per cycle
// and holds as a whole while a result is stalled. The line store starts
// undefined and needs no clearing pass.
// ----------------------------------------------------------------------------
module sixth_order_x_derivative_of_products_core #(
    parameter int MAX_COLS = 1024,
    parameter int BOUNDARY = 9
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic [1:0]        cfg_index,
    input  logic [30:0]       cfg_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  sodp_pkg::sample_t u_value,
    input  sodp_pkg::sample_t v_value,
    input  sodp_pkg::sample_t coef_u_first,
    input  sodp_pkg::sample_t coef_v_first,
    input  sodp_pkg::sample_t coef_u_second,
    input  sodp_pkg::sample_t coef_v_second,
    output logic              out_valid,
    input  logic              out_stall,
    output sodp_pkg::sample_t deriv_first,
    output sodp_pkg::sample_t deriv_second,
    output logic              last_point
);
    import sodp_pkg::*;

    localparam int CW     = $clog2(MAX_COLS);
    localparam int CMP_W  = (CW + 2 > 12) ? CW + 2 : 12;
    localparam int TAIL   = 7;

    // configuration
    logic [15:0] num_rows_reg;
    logic [10:0] num_cols_reg;
    logic [30:0] inv_spacing_reg;

    // counters
    logic [15:0]   row_reg;
    logic [15:0]   row_next;
    logic [CW-1:0] col_reg;
    logic [CW-1:0] col_next;

    logic adv;
    logic acc;

    logic [15:0]      rows;
    logic [CMP_W-1:0] cols;
    logic [CMP_W-1:0] cw_ext;
    logic [15:0]      j;
    meta_t            meta_in;

    // stage 1
    logic    s1_valid_reg;
    logic [CW-1:0] s1_col_reg;
    meta_t   s1_meta_reg;
    sample_t s1_u_reg, s1_v_reg, s1_cuf_reg, s1_cvf_reg, s1_cus_reg, s1_cvs_reg;
    logic    s1_wbhit_reg;
    line_t   mem_q_reg;
    line_t   wb_line_reg;
    line_t   line_sel;

    // stage 2
    logic    s2_valid_reg;
    logic [CW-1:0] s2_col_reg;
    meta_t   s2_meta_reg;
    line_t   s2_line_reg;
    logic signed [63:0] s2_puf_reg, s2_pvf_reg, s2_pus_reg, s2_pvs_reg;
    sample_t w_first;
    sample_t w_second;
    line_t   new_line;

    meta_t   tail_reg [TAIL];
    sample_t d_first;
    sample_t d_second;

    line_t   mem [MAX_COLS];

    // sum of two floored products, saturated to 32 bits
    function automatic sample_t wsum(input logic signed [63:0] pa,
                                     input logic signed [63:0] pb);
        logic signed [48:0] s;
        begin
            s = 49'(pa >>> 16) + 49'(pb >>> 16);
            if (s > 49'sd2147483647)
            begin
                return 32'sh7FFFFFFF;
            end
            else if (s < -49'sd2147483648)
            begin
                return 32'sh80000000;
            end
            return s[31:0];
        end
    endfunction

    assign in_stall = out_valid && out_stall;
    assign adv      = !in_stall;
    assign acc      = in_valid && adv;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg    <= 16'd1024;
            num_cols_reg    <= 11'd1024;
            inv_spacing_reg <= 31'd65536;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_NUM_ROWS:    num_rows_reg    <= cfg_data[15:0];
                CFG_NUM_COLS:    num_cols_reg    <= cfg_data[10:0];
                CFG_INV_SPACING: inv_spacing_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // effective grid size and per-request control
    always_comb
    begin
        rows = (num_rows_reg == 16'd0) ? 16'd1 : num_rows_reg;
        cols = CMP_W'(num_cols_reg);
        if (cols == '0)
        begin
            cols = CMP_W'(1);
        end
        else if (cols > CMP_W'(MAX_COLS))
        begin
            cols = CMP_W'(MAX_COLS);
        end
        cw_ext = CMP_W'(col_reg);
        j      = row_reg - 16'(HALF_WIDTH);
        meta_in.emit     = (row_reg >= 16'(HALF_WIDTH)) && (row_reg < rows);
        meta_in.interior = ({1'b0, j} >= 17'(BOUNDARY))
                        && (17'(j) + 17'(BOUNDARY) < {1'b0, rows})
                        && (cw_ext >= CMP_W'(BOUNDARY))
                        && (cw_ext + CMP_W'(BOUNDARY) < cols);
        meta_in.last     = (row_reg == rows - 16'd1) && (cw_ext == cols - CMP_W'(1));
        if (cw_ext + CMP_W'(1) >= cols)
        begin
            col_next = '0;
            row_next = ({1'b0, row_reg} + 17'd1 >= {1'b0, rows}) ? 16'd0
                                                                 : row_reg + 16'd1;
        end
        else
        begin
            col_next = col_reg + CW'(1);
            row_next = (row_reg >= rows) ? 16'd0 : row_reg;
        end
    end

    // grid position counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (acc)
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    // line store: read at request, write back from stage 2
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mem_q_reg <= mem[col_reg];
            if (s2_valid_reg)
            begin
                mem[s2_col_reg] <= new_line;
            end
        end
    end

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            for (int i = 0; i < TAIL; i++)
            begin
                tail_reg[i] <= '0;
            end
        end
        else if (adv)
        begin
            s1_valid_reg <= acc;
            s2_valid_reg <= s1_valid_reg;
            tail_reg[0]  <= s2_valid_reg ? s2_meta_reg : '0;
            for (int i = 1; i < TAIL; i++)
            begin
                tail_reg[i] <= tail_reg[i-1];
            end
        end
    end

    // forwarding of lines not yet in the store
    always_comb
    begin
        if (s2_valid_reg && (s2_col_reg == s1_col_reg))
        begin
            line_sel = new_line;
        end
        else if (s1_wbhit_reg)
        begin
            line_sel = wb_line_reg;
        end
        else
        begin
            line_sel = mem_q_reg;
        end
    end

    // stage 1 and stage 2 payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_col_reg   <= col_reg;
            s1_meta_reg  <= meta_in;
            s1_u_reg     <= u_value;
            s1_v_reg     <= v_value;
            s1_cuf_reg   <= coef_u_first;
            s1_cvf_reg   <= coef_v_first;
            s1_cus_reg   <= coef_u_second;
            s1_cvs_reg   <= coef_v_second;
            s1_wbhit_reg <= s2_valid_reg && (s2_col_reg == col_reg);
            if (s2_valid_reg)
            begin
                wb_line_reg <= new_line;
            end
            s2_col_reg   <= s1_col_reg;
            s2_meta_reg  <= s1_meta_reg;
            s2_line_reg  <= line_sel;
            s2_puf_reg   <= 64'(s1_u_reg) * 64'(s1_cuf_reg);
            s2_pvf_reg   <= 64'(s1_v_reg) * 64'(s1_cvf_reg);
            s2_pus_reg   <= 64'(s1_u_reg) * 64'(s1_cus_reg);
            s2_pvs_reg   <= 64'(s1_v_reg) * 64'(s1_cvs_reg);
        end
    end

    // weighted sums and shifted history
    assign w_first  = wsum(s2_puf_reg, s2_pvf_reg);
    assign w_second = wsum(s2_pus_reg, s2_pvs_reg);
    assign new_line.first  = {s2_line_reg.first[ROWS_KEPT-2:0], w_first};
    assign new_line.second = {s2_line_reg.second[ROWS_KEPT-2:0], w_second};

    // derivative datapaths
    sodp_deriv u_deriv_first (
        .clk         (clk),
        .en          (adv),
        .w           (w_first),
        .hist        (s2_line_reg.first),
        .inv_spacing (inv_spacing_reg),
        .deriv       (d_first)
    );

    sodp_deriv u_deriv_second (
        .clk         (clk),
        .en          (adv),
        .w           (w_second),
        .hist        (s2_line_reg.second),
        .inv_spacing (inv_spacing_reg),
        .deriv       (d_second)
    );

    // result request
    assign out_valid    = tail_reg[TAIL-1].emit;
    assign last_point   = tail_reg[TAIL-1].last;
    assign deriv_first  = tail_reg[TAIL-1].interior ? d_first : '0;
    assign deriv_second = tail_reg[TAIL-1].interior ? d_second : '0;

endmodule

@@ sv/sodp_deriv.sv @@
// ----------------------------------------------------------------------------
// sodp_deriv
// Stencil sum, scaling by the inverse spacing and floor divide by 60 with
// saturation, seven register stages, all advancing on en.
// ----------------------------------------------------------------------------
module sodp_deriv (
    input  logic             clk,
    input  logic             en,
    input  sodp_pkg::sample_t w,
    input  sodp_pkg::hist_t   hist,
    input  logic [30:0]       inv_spacing,
    output sodp_pkg::sample_t deriv
);
    import sodp_pkg::*;

    sample_t           w_reg;
    hist_t             hist_reg;
    logic signed [39:0] s_reg;
    logic signed [39:0] s_next;
    logic signed [55:0] phi_reg;
    logic signed [56:0] plo_reg;
    logic [35:0]        y_reg;
    logic [35:0]        y_next;
    logic [35:0]        ye_reg;
    logic [50:0]        pph_reg;
    logic [50:0]        ppl_reg;
    logic [35:0]        yf_reg;
    logic [31:0]        q0_reg;
    logic [31:0]        q0_next;
    sample_t            deriv_reg;
    sample_t            deriv_next;

    logic signed [32:0] d1;
    logic signed [32:0] d2;
    logic signed [32:0] d3;
    logic signed [39:0] e1;
    logic signed [39:0] e2;
    logic signed [39:0] e3;
    logic signed [15:0] hi_s;
    logic signed [16:0] lo_s;
    logic signed [56:0] t;
    logic [37:0]        xc;
    logic [68:0]        prod;
    logic [35:0]        rem;
    logic [31:0]        q;

    // dividend minus 15 times the quotient estimate
    function automatic logic [35:0] residue15(input logic [35:0] y,
                                              input logic [31:0] q0);
        logic [35:0] m;
        begin
            m = (36'(q0) << 4) - 36'(q0);
            return y - m;
        end
    endfunction

    // stencil sum 45*d1 - 9*d2 + d3
    always_comb
    begin
        d1 = 33'($signed(hist_reg[1])) - 33'($signed(hist_reg[3]));
        d2 = 33'($signed(hist_reg[0])) - 33'($signed(hist_reg[4]));
        d3 = 33'(w_reg) - 33'($signed(hist_reg[5]));
        e1 = 40'(d1);
        e2 = 40'(d2);
        e3 = 40'(d3);
        s_next = (e1 <<< 5) + (e1 <<< 3) + (e1 <<< 2) + e1
               - ((e2 <<< 3) + e2) + e3;
    end

    // split inverse spacing into integer and fraction parts
    assign hi_s = $signed({1'b0, inv_spacing[30:16]});
    assign lo_s = $signed({1'b0, inv_spacing[15:0]});

    // combine, clamp and offset to a non-negative dividend, then drop 2 bits
    always_comb
    begin
        t = 57'(phi_reg) + 57'(plo_reg >>> 16);
        if (t < T_MIN)
        begin
            xc = '0;
        end
        else if (t > T_MAX)
        begin
            xc = X_MAX;
        end
        else
        begin
            xc = 38'(t - T_MIN);
        end
        y_next = xc[37:2];
    end

    // quotient estimate from the reciprocal product
    always_comb
    begin
        prod    = (69'(pph_reg) << 18) + 69'(ppl_reg);
        q0_next = prod[67:36];
    end

    // one correction step, then remove the offset
    always_comb
    begin
        rem = residue15(yf_reg, q0_reg);
        q   = (rem >= 36'd15) ? q0_reg + 32'd1 : q0_reg;
        deriv_next = $signed({~q[31], q[30:0]});
    end

    // pipeline registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w_reg     <= w;
            hist_reg  <= hist;
            s_reg     <= s_next;
            phi_reg   <= 56'(s_reg) * 56'(hi_s);
            plo_reg   <= 57'(s_reg) * 57'(lo_s);
            y_reg     <= y_next;
            ye_reg    <= y_reg;
            pph_reg   <= 51'(y_reg[35:18]) * 51'(RECIP_15);
            ppl_reg   <= 51'(y_reg[17:0]) * 51'(RECIP_15);
            yf_reg    <= ye_reg;
            q0_reg    <= q0_next;
            deriv_reg <= deriv_next;
        end
    end

    assign deriv = deriv_reg;

endmodule
